[rtl/tbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants of the TFTP block sender
// Command, event, phase and action codes, the event record that the front end
// hands to the protocol engine, and the effective configuration record.
// ----------------------------------------------------------------------------
package tbs_pkg;

   localparam int MAX_BLOCK_BYTES = 512;

   localparam logic [15:0] MIN_PACKET_BYTES = 16'd4;
   localparam logic [15:0] OPCODE_ACK       = 16'd4;

   // Configuration register indexes and reset values.
   localparam logic [1:0]  CSR_BLOCK_SIZE      = 2'd0;
   localparam logic [1:0]  CSR_ACK_TIMEOUT     = 2'd1;
   localparam logic [1:0]  CSR_MAX_RETRANSMITS = 2'd2;
   localparam logic [9:0]  BLOCK_SIZE_RESET    = 10'd512;
   localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd50;
   localparam logic [7:0]  MAX_RETX_RESET      = 8'd3;

   // Depth of the event queue between front end and engine.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_PACKET = 2'd2,
      CMD_CHUNK  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_TICK  = 2'd1,
      EV_ACK   = 2'd2,
      EV_CHUNK = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_WAIT_ACK0  = 2'd1,
      PH_WAIT_CHUNK = 2'd2,
      PH_WAIT_ACK   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_WRQ        = 3'd0,
      ACT_REQ_CHUNK  = 3'd1,
      ACT_SEND       = 3'd2,
      ACT_DONE       = 3'd3,
      ACT_NO_SERVER  = 3'd4,
      ACT_RETRY_FAIL = 3'd5
   } action_type;

   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    blk;
      logic [9:0]     len;
   } event_type;

   typedef struct packed {
      logic [9:0]  eff_block_size;
      logic [15:0] ack_timeout;
      logic [7:0]  max_retx;
   } cfg_type;

endpackage

[rtl/tbs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_if: channel interfaces of the TFTP block sender
// Request channel carrying events in, response channel carrying actions out.
// ----------------------------------------------------------------------------
interface tbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] packet_length;
   logic [15:0] packet_opcode;
   logic [15:0] packet_block;
   logic [9:0]  chunk_length;

   modport source (output valid, command, packet_length, packet_opcode, packet_block,
                   chunk_length, input ready);
   modport sink   (input valid, command, packet_length, packet_opcode, packet_block,
                   chunk_length, output ready);
endinterface

interface tbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] block_number;
   logic [9:0]  send_length;

   modport source (output valid, action, block_number, send_length, input ready);
   modport sink   (input valid, action, block_number, send_length, output ready);
endinterface

[rtl/tftp_block_sender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_block_sender: sending side of a TFTP write transfer
// Turns start, tick, packet and chunk events into write request, chunk
// request, data send, completion and failure actions.
// ----------------------------------------------------------------------------
// The block takes one event transaction per clock cycle while the queue has
// room, and gives at most one action per event, in order. An event passes
// the front end in the cycle it is accepted, waits in a two-entry queue, and
// is handled by the protocol engine, which registers its action in the
// response register. The engine handles one event per cycle as long as the
// response register is free or being drained, which sets the sustained rate
// at one event per cycle. Packets that are not well-formed acknowledgements
// are dropped at the front end and never occupy the queue. Configuration
// writes are meant to be made while no transfer events are in flight.
// ----------------------------------------------------------------------------
module tftp_block_sender
   import tbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tbs_req_if.sink     req_if,
   tbs_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type   cfg;
   logic      push_valid, push_ready;
   event_type push_event;
   logic      pop_valid, pop_ready;
   event_type pop_event;

   tbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbs_front u_front (
      .cfg        (cfg),
      .req        (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event)
   );

   tbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_event  (pop_event)
   );

   tbs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .ev_valid (pop_valid),
      .ev_ready (pop_ready),
      .ev       (pop_event),
      .rsp      (rsp_if)
   );

endmodule

[rtl/tbs_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_csr: configuration registers
// Holds block size, ACK timeout and retry limit, and presents the block size
// already limited to the largest supported block.
// ----------------------------------------------------------------------------
module tbs_csr
   import tbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   logic [9:0]  block_size_ff;
   logic [15:0] ack_timeout_ff;
   logic [7:0]  max_retx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         max_retx_ff    <= MAX_RETX_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_SIZE:      block_size_ff  <= csr_wdata[9:0];
            CSR_ACK_TIMEOUT:     ack_timeout_ff <= csr_wdata;
            CSR_MAX_RETRANSMITS: max_retx_ff    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (11'(block_size_ff) > 11'(MAX_BLOCK_BYTES)) begin
         cfg.eff_block_size = 10'(MAX_BLOCK_BYTES);
      end else begin
         cfg.eff_block_size = block_size_ff;
      end
      cfg.ack_timeout = ack_timeout_ff;
      cfg.max_retx    = max_retx_ff;
   end

endmodule

[rtl/tbs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_front: event front end
// Accepts request transactions, drops packets that are not acknowledgements,
// clamps chunk lengths and pushes the classified event into the queue.
// ----------------------------------------------------------------------------
module tbs_front
   import tbs_pkg::*;
(
   input  cfg_type    cfg,
   tbs_req_if.sink    req,
   output logic       push_valid,
   input  logic       push_ready,
   output event_type  push_event
);

   logic is_ack;

   assign req.ready = push_ready;
   assign is_ack    = (req.packet_length >= MIN_PACKET_BYTES) &&
                      (req.packet_opcode == OPCODE_ACK);

   always_comb begin
      push_event.blk = req.packet_block;
      push_event.len = (req.chunk_length > cfg.eff_block_size) ? cfg.eff_block_size
                                                               : req.chunk_length;
      push_valid     = req.valid;
      case (command_type'(req.command))
         CMD_START:  push_event.kind = EV_START;
         CMD_TICK:   push_event.kind = EV_TICK;
         CMD_PACKET: begin
            push_event.kind = EV_ACK;
            // Anything other than a well-formed ACK never reaches the engine.
            push_valid      = req.valid && is_ack;
         end
         CMD_CHUNK:  push_event.kind = EV_CHUNK;
         default:    push_event.kind = EV_TICK;
      endcase
   end

endmodule

[rtl/tbs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_queue: event queue
// Short first-in first-out buffer that decouples the front end from the
// protocol engine.
// ----------------------------------------------------------------------------
module tbs_queue
   import tbs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  event_type push_event,
   output logic      pop_valid,
   input  logic      pop_ready,
   output event_type pop_event
);

   event_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_event  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

[rtl/tbs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_back: transfer protocol engine
// Runs the write-transfer state machine on queued events, keeps the block
// number, ACK timer and attempt count, and drives the response register.
// ----------------------------------------------------------------------------
module tbs_back
   import tbs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      ev_valid,
   output logic      ev_ready,
   input  event_type ev,
   tbs_rsp_if.source rsp
);

   phase_type   phase_ff, phase_in;
   logic [15:0] current_block_ff, current_block_in;
   logic [15:0] wait_timer_ff, wait_timer_in;
   logic [7:0]  attempt_count_ff, attempt_count_in;
   logic [9:0]  last_len_ff, last_len_in;

   logic        rsp_valid_ff, rsp_valid_in;
   action_type  action_ff, action_in;
   logic [15:0] block_number_ff, block_number_in;
   logic [9:0]  send_length_ff, send_length_in;

   logic        take;
   logic        emit;
   logic [15:0] timer_inc;
   logic        timed_out;
   logic        waiting_ack;
   logic        ack0_match, ack_match, block_full, retry_left;

   // The engine moves on whenever the response register is free or drained.
   assign ev_ready    = !rsp_valid_ff || rsp.ready;
   assign take        = ev_valid && ev_ready;
   assign timer_inc   = wait_timer_ff + 16'd1;
   assign timed_out   = (timer_inc >= cfg.ack_timeout);
   assign waiting_ack = (phase_ff == PH_WAIT_ACK0) || (phase_ff == PH_WAIT_ACK);
   assign ack0_match  = (phase_ff == PH_WAIT_ACK0) && (ev.blk == 16'd0);
   assign ack_match   = (phase_ff == PH_WAIT_ACK) && (ev.blk == current_block_ff);
   assign block_full  = (last_len_ff == cfg.eff_block_size);
   assign retry_left  = (attempt_count_ff < cfg.max_retx);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (ev.kind)
            EV_START: phase_in = PH_WAIT_ACK0;
            EV_TICK: begin
               if (waiting_ack && timed_out) begin
                  if (phase_ff == PH_WAIT_ACK0 || !retry_left) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            EV_ACK: begin
               if (ack0_match) begin
                  phase_in = PH_WAIT_CHUNK;
               end else if (ack_match) begin
                  phase_in = block_full ? PH_WAIT_CHUNK : PH_IDLE;
               end
            end
            EV_CHUNK: begin
               if (phase_ff == PH_WAIT_CHUNK) begin
                  phase_in = PH_WAIT_ACK;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Transfer counters and the response for this event.
   always_comb begin
      current_block_in = current_block_ff;
      wait_timer_in    = wait_timer_ff;
      attempt_count_in = attempt_count_ff;
      last_len_in      = last_len_ff;
      emit             = 1'b0;
      action_in        = action_ff;
      block_number_in  = 16'd0;
      send_length_in   = 10'd0;
      if (take) begin
         case (ev.kind)
            EV_START: begin
               current_block_in = 16'd0;
               wait_timer_in    = 16'd0;
               attempt_count_in = 8'd0;
               last_len_in      = 10'd0;
               emit             = 1'b1;
               action_in        = ACT_WRQ;
            end
            EV_TICK: begin
               if (waiting_ack) begin
                  if (!timed_out) begin
                     wait_timer_in = timer_inc;
                  end else begin
                     wait_timer_in = 16'd0;
                     emit          = 1'b1;
                     if (phase_ff == PH_WAIT_ACK0) begin
                        action_in = ACT_NO_SERVER;
                     end else if (!retry_left) begin
                        action_in = ACT_RETRY_FAIL;
                     end else begin
                        attempt_count_in = attempt_count_ff + 8'd1;
                        action_in        = ACT_SEND;
                        block_number_in  = current_block_ff;
                        send_length_in   = last_len_ff;
                     end
                  end
               end
            end
            EV_ACK: begin
               if (ack0_match) begin
                  current_block_in = 16'd1;
                  wait_timer_in    = 16'd0;
                  emit             = 1'b1;
                  action_in        = ACT_REQ_CHUNK;
                  block_number_in  = 16'd1;
               end else if (ack_match) begin
                  wait_timer_in = 16'd0;
                  emit          = 1'b1;
                  if (block_full) begin
                     current_block_in = current_block_ff + 16'd1;
                     action_in        = ACT_REQ_CHUNK;
                     block_number_in  = current_block_ff + 16'd1;
                  end else begin
                     action_in = ACT_DONE;
                  end
               end
            end
            EV_CHUNK: begin
               if (phase_ff == PH_WAIT_CHUNK) begin
                  last_len_in      = ev.len;
                  attempt_count_in = 8'd1;
                  wait_timer_in    = 16'd0;
                  emit             = 1'b1;
                  action_in        = ACT_SEND;
                  block_number_in  = current_block_ff;
                  send_length_in   = ev.len;
               end
            end
            default: begin
            end
         endcase
      end
      if (take) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         current_block_ff <= 16'd0;
         wait_timer_ff    <= 16'd0;
         attempt_count_ff <= 8'd0;
         last_len_ff      <= 10'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         current_block_ff <= current_block_in;
         wait_timer_ff    <= wait_timer_in;
         attempt_count_ff <= attempt_count_in;
         last_len_ff      <= last_len_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         action_ff       <= action_in;
         block_number_ff <= block_number_in;
         send_length_ff  <= send_length_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.action       = action_ff;
   assign rsp.block_number = block_number_ff;
   assign rsp.send_length  = send_length_ff;

endmodule

[dv/tftp_block_sender_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_block_sender_checker: transfer predictor and action scoreboard
// Watches the event, action and register write ports of the TFTP block sender.
// It keeps its own copy of the transfer state, predicts the action of every
// accepted event and compares each accepted action with the oldest prediction.
// ----------------------------------------------------------------------------
module tftp_block_sender_checker
   import tbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tbs_req_if          req_mon,
   tbs_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      action_type  action;
      logic [15:0] block_number;
      logic [9:0]  send_length;
   } action_rec_type;

   logic [9:0]  block_size;
   logic [15:0] ack_timeout;
   logic [7:0]  max_retx;

   phase_type   phase;
   logic [15:0] cur_block;
   logic [15:0] wait_timer;
   logic [7:0]  attempts;
   logic [9:0]  last_len;

   action_rec_type expected_actions[$];

   // Updates the transfer state for one event and tells whether it makes an action.
   function automatic bit advance_transfer(input command_type cmd,
         input logic [15:0] plen, input logic [15:0] opcode, input logic [15:0] pblk,
         input logic [9:0] clen, output action_rec_type rec);
      logic [9:0] full;
      full = (block_size > MAX_BLOCK_BYTES) ? 10'(MAX_BLOCK_BYTES) : block_size;
      rec.action       = ACT_WRQ;
      rec.block_number = '0;
      rec.send_length  = '0;
      case (cmd)
         CMD_START: begin
            // A start always abandons whatever transfer is in progress.
            phase      = PH_WAIT_ACK0;
            cur_block  = '0;
            wait_timer = '0;
            attempts   = '0;
            last_len   = '0;
            return 1'b1;
         end
         CMD_TICK: begin
            if (phase != PH_WAIT_ACK0 && phase != PH_WAIT_ACK) return 1'b0;
            wait_timer = wait_timer + 16'd1;
            if (wait_timer < ack_timeout) return 1'b0;
            wait_timer = '0;
            if (phase == PH_WAIT_ACK0) begin
               phase      = PH_IDLE;
               rec.action = ACT_NO_SERVER;
               return 1'b1;
            end
            if (attempts >= max_retx) begin
               phase      = PH_IDLE;
               rec.action = ACT_RETRY_FAIL;
               return 1'b1;
            end
            attempts         = attempts + 8'd1;
            rec.action       = ACT_SEND;
            rec.block_number = cur_block;
            rec.send_length  = last_len;
            return 1'b1;
         end
         CMD_PACKET: begin
            if (plen < MIN_PACKET_BYTES || opcode != OPCODE_ACK) return 1'b0;
            if (phase == PH_WAIT_ACK0 && pblk == 16'd0) begin
               phase            = PH_WAIT_CHUNK;
               cur_block        = 16'd1;
               wait_timer       = '0;
               rec.action       = ACT_REQ_CHUNK;
               rec.block_number = cur_block;
               return 1'b1;
            end
            if (phase == PH_WAIT_ACK && pblk == cur_block) begin
               wait_timer = '0;
               // Only a full block keeps the transfer going.
               if (last_len == full) begin
                  phase            = PH_WAIT_CHUNK;
                  cur_block        = cur_block + 16'd1;
                  rec.action       = ACT_REQ_CHUNK;
                  rec.block_number = cur_block;
                  return 1'b1;
               end
               phase      = PH_IDLE;
               rec.action = ACT_DONE;
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            if (phase != PH_WAIT_CHUNK) return 1'b0;
            last_len         = (clen > full) ? full : clen;
            attempts         = 8'd1;
            wait_timer       = '0;
            phase            = PH_WAIT_ACK;
            rec.action       = ACT_SEND;
            rec.block_number = cur_block;
            rec.send_length  = last_len;
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      action_rec_type want;
      if (reset) begin
         block_size  = BLOCK_SIZE_RESET;
         ack_timeout = ACK_TIMEOUT_RESET;
         max_retx    = MAX_RETX_RESET;
         phase       = PH_IDLE;
         cur_block   = '0;
         wait_timer  = '0;
         attempts    = '0;
         last_len    = '0;
         expected_actions.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_actions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: action %0d block %0d length %0d arrived with none expected",
                           $realtime, rsp_mon.action, rsp_mon.block_number,
                           rsp_mon.send_length);
            end else begin
               want = expected_actions.pop_front();
               checked_count++;
               if (rsp_mon.action !== want.action
                     || rsp_mon.block_number !== want.block_number
                     || rsp_mon.send_length !== want.send_length) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: expected action %0d block %0d length %0d, got %0d %0d %0d",
                              $realtime, want.action, want.block_number, want.send_length,
                              rsp_mon.action, rsp_mon.block_number, rsp_mon.send_length);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BLOCK_SIZE:      block_size  = csr_wdata[9:0];
               CSR_ACK_TIMEOUT:     ack_timeout = csr_wdata;
               CSR_MAX_RETRANSMITS: max_retx    = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (advance_transfer(command_type'(req_mon.command), req_mon.packet_length,
                                 req_mon.packet_opcode, req_mon.packet_block,
                                 req_mon.chunk_length, want))
               expected_actions.push_back(want);
         end
      end
      pending_count = expected_actions.size();
   end

endmodule

[dv/tftp_block_sender_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tftp_block_sender_tb: testbench top of the TFTP block sender
// Runs a short directed sequence and then randomized write transfers under
// a range of register settings, with random gaps on both channels. The
// checker beside the block predicts and compares every action.
// ----------------------------------------------------------------------------
module tftp_block_sender_tb;
   import tbs_pkg::*;

   localparam int QUIET_LIMIT        = 2000;
   localparam int SETTLE_CYCLES      = 8;
   localparam int EVENTS_PER_SETTING = 55;
   localparam int RANDOM_SETTINGS    = 8;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   tbs_req_if req_ch();
   tbs_rsp_if rsp_ch();

   int mismatch_count;
   int pending_count;
   int checked_count;
   int events_sent    = 0;
   int settings_used  = 0;
   int quiet_cycles   = 0;
   bit gaps_on        = 1'b0;

   logic [9:0]  cfg_block;
   logic [15:0] cfg_timeout;
   logic [7:0]  cfg_retx;

   tftp_block_sender i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tftp_block_sender_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Action channel backpressure in random bursts.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // The run is stuck if no transaction completes for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Presents one event and returns at the edge where it is accepted, with
   // valid still high so that the next event can follow without a bubble.
   task automatic put_event(input command_type cmd, input logic [15:0] plen,
         input logic [15:0] opcode, input logic [15:0] pblk, input logic [9:0] clen);
      if (gaps_on && $urandom_range(0, 6) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.packet_length <= plen;
      req_ch.packet_opcode <= opcode;
      req_ch.packet_block  <= pblk;
      req_ch.chunk_length  <= clen;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      events_sent++;
   endtask

   task automatic send_ack(input logic [15:0] blk);
      put_event(CMD_PACKET, 16'($urandom_range(4, 1500)), OPCODE_ACK, blk, 10'($urandom));
   endtask

   task automatic send_ticks(input int count);
      repeat (count)
         put_event(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
   endtask

   // Stray events: fully random ones, or acknowledgements that are short
   // or carry a small, usually wrong, block number.
   task automatic send_noise();
      command_type cmd;
      if ($urandom_range(0, 2) == 0) begin
         put_event(CMD_PACKET, 16'($urandom_range(0, 7)), OPCODE_ACK,
                   16'($urandom_range(0, 7)), 10'($urandom));
      end else begin
         cmd = ($urandom_range(0, 7) == 0) ? CMD_START : command_type'($urandom_range(1, 3));
         put_event(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
      end
   endtask

   function automatic int pick_ticks(input bit first_wait);
      if (cfg_timeout > 12) return $urandom_range(0, 3);
      if ($urandom_range(0, first_wait ? 7 : 3) == 0)
         return cfg_timeout + $urandom_range(0, 2 * cfg_timeout + 1);
      return (cfg_timeout == 0) ? 0 : $urandom_range(0, cfg_timeout - 1);
   endfunction

   // Waits until every predicted action has come out and the block is quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [9:0] blk_size, input logic [15:0] timeout,
         input logic [7:0] retx);
      settle();
      write_csr(CSR_BLOCK_SIZE, 16'(blk_size));
      write_csr(CSR_ACK_TIMEOUT, timeout);
      write_csr(CSR_MAX_RETRANSMITS, 16'(retx));
      csr_wr_en   <= 1'b0;
      cfg_block   = blk_size;
      cfg_timeout = timeout;
      cfg_retx    = retx;
      settings_used++;
   endtask

   // A write transfer of a few blocks with ticks and stray packets mixed in.
   task automatic random_transfer();
      int          blocks;
      int          i;
      logic [9:0]  full;
      logic [9:0]  clen;
      blocks = $urandom_range(1, 6);
      full   = (cfg_block > MAX_BLOCK_BYTES) ? 10'(MAX_BLOCK_BYTES) : cfg_block;
      put_event(CMD_START, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
      send_ticks(pick_ticks(1'b1));
      if ($urandom_range(0, 4) == 0) send_noise();
      send_ack(16'd0);
      for (i = 1; i <= blocks; i++) begin
         if (i < blocks || $urandom_range(0, 5) == 0)
            clen = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(full, 1023)) : full;
         else
            clen = (full == 0) ? 10'd0 : 10'($urandom_range(0, full - 1));
         put_event(CMD_CHUNK, 16'($urandom), 16'($urandom), 16'($urandom), clen);
         send_ticks(pick_ticks(1'b0));
         if ($urandom_range(0, 4) == 0) send_noise();
         if ($urandom_range(0, 7) == 0) send_ack(16'(i - 1));
         send_ack(16'(i));
      end
   endtask

   initial begin
      int s;
      int phase_start;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_BLOCK_SIZE;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.command       = CMD_TICK;
      req_ch.packet_length = '0;
      req_ch.packet_opcode = '0;
      req_ch.packet_block  = '0;
      req_ch.chunk_length  = '0;
      cfg_block            = BLOCK_SIZE_RESET;
      cfg_timeout          = ACK_TIMEOUT_RESET;
      cfg_retx             = MAX_RETX_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a tick while idle, malformed and unmatched packets,
      // an oversized chunk clamped to a full block, then an empty last block.
      put_event(CMD_TICK, '0, '0, '0, '0);
      put_event(CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
      put_event(CMD_PACKET, 16'd3, OPCODE_ACK, 16'd0, '0);
      put_event(CMD_PACKET, 16'd4, 16'd5, 16'd0, '0);
      put_event(CMD_PACKET, 16'd4, OPCODE_ACK, 16'd7, '0);
      put_event(CMD_PACKET, 16'hFFFF, OPCODE_ACK, 16'd0, '0);
      put_event(CMD_CHUNK, '0, '0, '0, 10'h3FF);
      send_ack(16'd1);
      put_event(CMD_CHUNK, '0, '0, '0, 10'd0);
      send_ack(16'd2);

      // One-tick timeout: missing server, retransmit, retry limit and
      // a start that aborts a transfer in progress.
      apply_setting(10'd4, 16'd1, 8'd2);
      put_event(CMD_CHUNK, '0, '0, '0, 10'd4);
      put_event(CMD_START, '0, '0, '0, '0);
      put_event(CMD_TICK, '0, '0, '0, '0);
      put_event(CMD_START, '0, '0, '0, '0);
      send_ack(16'd0);
      put_event(CMD_TICK, '0, '0, '0, '0);
      put_event(CMD_CHUNK, '0, '0, '0, 10'd4);
      put_event(CMD_TICK, '0, '0, '0, '0);
      put_event(CMD_TICK, '0, '0, '0, '0);
      put_event(CMD_START, '0, '0, '0, '0);
      send_ack(16'd0);
      put_event(CMD_START, '0, '0, '0, '0);
      send_ack(16'd0);
      put_event(CMD_CHUNK, '0, '0, '0, 10'd3);
      send_ack(16'd1);

      for (s = 0; s < RANDOM_SETTINGS; s++) begin
         case (s)
            0:       apply_setting(10'd1, 16'd3, 8'd1);
            1:       apply_setting(10'd0, 16'd1, 8'd0);
            2:       apply_setting(10'd16, 16'd0, 8'd255);
            3:       apply_setting(10'd512, 16'd65535, 8'd255);
            4:       apply_setting(10'd1023, 16'd5, 8'd3);
            default: apply_setting(10'($urandom_range(1, 32)), 16'($urandom_range(1, 8)),
                                   8'($urandom_range(1, 4)));
         endcase
         phase_start = events_sent;
         while (events_sent - phase_start < EVENTS_PER_SETTING) begin
            // The final setting runs without gaps on either channel.
            gaps_on = (s != RANDOM_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
               send_noise();
            else
               random_transfer();
         end
      end
      gaps_on = 1'b0;
      settle();

      $display("Sent %0d events and checked %0d actions under %0d register settings,",
               events_sent, checked_count, settings_used);
      $display("with timeouts, retransmit limits, aborted and clamped transfers.");
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/tbs_pkg.sv
rtl/tbs_if.sv
rtl/tbs_csr.sv
rtl/tbs_front.sv
rtl/tbs_queue.sv
rtl/tbs_back.sv
rtl/tftp_block_sender.sv
dv/tftp_block_sender_checker.sv
dv/tftp_block_sender_tb.sv
